// ===== hw/rtl/maf_pkg.sv =====
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared widths, register map constants and the controller command word.
// ----------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int WIN_W           = 4;
  localparam int MAX_WINDOW_DEF  = 10;
  localparam int DEFAULT_WINDOW  = 5;
  localparam logic [WIN_W-1:0] MIN_WINDOW = 4'd2;

  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted sample, RAM read of the oldest slot
    logic update;    // update the running sum, write the slot, advance
    logic div_load;  // load the divider with the magnitude of the sum
    logic div_step;  // one restoring division step
    logic out_load;  // move the quotient into the output register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/maf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/maf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Moving average filter controller
// Sequences capture, sum update, division steps and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_ctrl #(
  parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output maf_pkg::ctrl_cmd_t     cmd
);

  localparam int SUM_W  = maf_pkg::SAMPLE_W + $clog2(MAX_WINDOW + 1);
  localparam int CNT_W  = $clog2(SUM_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_ABS  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] step_cnt;
  logic             out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = ST_ABS;
      end
      ST_ABS: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_cnt == CNT_W'(SUM_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        step_cnt <= step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/maf_datapath.sv =====
// ----------------------------------------------------------------------------
// Moving average filter datapath
// Window RAM, running sum, slot and fill count, and a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_datapath #(
  parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire maf_pkg::ctrl_cmd_t                cmd,
  input  wire logic                              cfg_we,
  input  wire logic [maf_pkg::WIN_W-1:0]         cfg_wdata,
  input  wire logic [maf_pkg::SAMPLE_W-1:0]      sample_in,
  output logic      [maf_pkg::WIN_W-1:0]         window_size,
  output logic      [maf_pkg::SAMPLE_W-1:0]      average
);

  localparam int SW     = maf_pkg::SAMPLE_W;
  localparam int WW     = maf_pkg::WIN_W;
  localparam int SUM_W  = SW + $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int CMP_W  = (SLOT_W + 1 > WW) ? SLOT_W + 1 : WW;
  localparam logic [WW-1:0] RST_WINDOW =
    WW'((maf_pkg::DEFAULT_WINDOW <= MAX_WINDOW) ? maf_pkg::DEFAULT_WINDOW : MAX_WINDOW);

  logic [SW-1:0]          sample;
  logic signed [SUM_W-1:0] sum;
  logic [SLOT_W-1:0]      slot;
  logic [WW-1:0]          count;
  logic [SW-1:0]          old_val;
  logic [SW-1:0]          ram_rdata;
  logic signed [SUM_W-1:0] sum_next;
  logic [CMP_W-1:0]       slot_inc;
  logic                   cfg_legal;

  logic                   neg;
  logic [SUM_W-1:0]       dq;
  logic [WW-1:0]          rem;
  logic [WW:0]            trial;
  logic                   q_bit;

  maf_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WINDOW)
  ) u_window_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot),
    .wdata (sample),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // While the window is still filling, the slot being replaced was never
  // written since the last clear and counts as zero.
  assign old_val  = (count == window_size) ? ram_rdata : '0;
  assign sum_next = sum - SUM_W'(signed'(old_val)) + SUM_W'(signed'(sample));
  assign slot_inc = CMP_W'(slot) + 1'b1;

  assign cfg_legal = (cfg_wdata >= maf_pkg::MIN_WINDOW) && (32'(cfg_wdata) <= MAX_WINDOW);

  // Restoring division step, remainder stays below the count.
  assign trial = {rem, dq[SUM_W-1]};
  assign q_bit = (trial >= {1'b0, count});

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= RST_WINDOW;
      sum         <= '0;
      slot        <= '0;
      count       <= '0;
    end else if (cfg_we && cfg_legal) begin
      window_size <= cfg_wdata;
      sum         <= '0;
      slot        <= '0;
      count       <= '0;
    end else if (cmd.update) begin
      sum <= sum_next;
      if (slot_inc >= CMP_W'(window_size)) begin
        slot <= '0;
      end else begin
        slot <= SLOT_W'(slot_inc);
      end
      if (count < window_size) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= sample_in;
    end
    if (cmd.div_load) begin
      neg <= sum[SUM_W-1];
      dq  <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      rem <= '0;
    end else if (cmd.div_step) begin
      dq  <= {dq[SUM_W-2:0], q_bit};
      rem <= q_bit ? WW'(trial - {1'b0, count}) : trial[WW-1:0];
    end
    if (cmd.out_load) begin
      average <= neg ? SW'(-dq[SW-1:0]) : dq[SW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/moving_average_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Moving average filter unit
// Averages the most recent window_size signed samples over a circular window.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                Word contents
//   s_*       in         s_tvalid / s_tready      sample, signed 16 bits
//   m_*       out        m_tvalid / m_tready      average, signed 16 bits
//   APB       in/out     psel, penable, pready    window_size at byte address 0
//
// The average word passes through the capture, sum update, divider load,
// division step and done states before it reaches the output register, and
// the next sample can be accepted once the controller is idle again; the
// bit-serial restoring divider, one quotient bit per cycle over the width
// of the running sum, takes the most steps in this sequence.
// One sample is processed at a time; s_tready is high while the controller
// is idle, also while a finished word still waits in the output register.
// A finished word waits in the controller until the output register is free.
// Reset is synchronous, clears the sum, slot and fill count, and loads the
// default window size.
// No clearing pass is needed: the fill count masks slots not yet written.
//
`default_nettype none

module moving_average_filter_unit #(
  parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream, s_tdata: [15:0] sample.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [maf_pkg::SAMPLE_W-1:0]    s_tdata,
  // Output stream, m_tdata: [15:0] average.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [maf_pkg::SAMPLE_W-1:0]    m_tdata,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [maf_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [maf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [maf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  maf_pkg::ctrl_cmd_t             cmd;
  logic                           cfg_we;
  logic [maf_pkg::WIN_W-1:0]      window_size;

  // The register file has a single register; the word address is paddr[2].
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == maf_pkg::REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == maf_pkg::REG_WINDOW_SIZE) ?
                  maf_pkg::APB_DATA_W'(window_size) : '0;

  maf_ctrl #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  maf_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[maf_pkg::WIN_W-1:0]),
    .sample_in   (s_tdata),
    .window_size (window_size),
    .average     (m_tdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/maf_checker.sv =====
// ----------------------------------------------------------------------------
// Moving average filter port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [maf_pkg::SAMPLE_W-1:0]    m_tdata,
  input wire logic                            pready
);

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // Reset leaves no word on the output.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // The block works on one sample at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second sample taken while one is in work");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk)
    pready)
    else $error("pready low");

endmodule

bind moving_average_filter_unit maf_checker u_maf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);

`default_nettype wire
